/* src/ukl_pkg.sv */
// Shared types and constants for the identifier-keyed lookup table.
`timescale 1ns / 1ps

package ukl_pkg;

  // Stored and probed key: byte count plus masked identifier bytes.
  typedef struct packed {
    logic [3:0]  len;
    logic [15:0] hi;
    logic [63:0] lo;
  } key_t;

  localparam int KeyW = $bits(key_t);

  // Valid identifier byte counts.
  localparam logic [3:0] LEN4  = 4'd4;
  localparam logic [3:0] LEN7  = 4'd7;
  localparam logic [3:0] LEN10 = 4'd10;

  // Result status codes.
  localparam logic [2:0] STAT_ADDED    = 3'd0;
  localparam logic [2:0] STAT_REPLACED = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_BADLEN   = 3'd3;
  localparam logic [2:0] STAT_HIT      = 3'd4;
  localparam logic [2:0] STAT_MISS     = 3'd5;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

endpackage

/* src/ukl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ukl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/ukl_key_cmp.sv */
// Shared key comparator: length and masked identifier bytes.
`timescale 1ns / 1ps

module ukl_key_cmp (
  input  ukl_pkg::key_t stored_key,
  input  ukl_pkg::key_t probe_key,
  output logic          eq
);

  logic len_eq;
  logic lo_eq;
  logic hi_eq;

  assign len_eq = (stored_key.len == probe_key.len);
  assign lo_eq  = (stored_key.lo == probe_key.lo);
  assign hi_eq  = (stored_key.hi == probe_key.hi);
  assign eq     = len_eq & lo_eq & hi_eq;

endmodule

/* src/uid_keyed_lookup_table_core.sv */
// Top level of the identifier-keyed lookup table: scan sequencer and storage.
`timescale 1ns / 1ps

//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_ready    | command, uid_low, uid_high, uid_length, payload
//  out     | out_valid / out_ready  | status, found_payload, entry_slot
//
// Each item is captured, then scanned: the key RAM is read once per held entry
// (at most ENTRIES), each registered read is compared against the probe key, and
// the result is handed to the output register. A match ends the scan early;
// a bad length skips it. in_ready is high only when no item is in work. A result
// waiting in the output register does not block intake; the next item is scanned
// and holds in the final step until that register frees up. Reset clears the count.

module uid_keyed_lookup_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [63:0] in_uid_low,
  input  logic [15:0] in_uid_high,
  input  logic [3:0]  in_uid_length,
  input  logic [15:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_found_payload,
  output logic [3:0]  out_entry_slot
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // Sequencer and item registers
  state_t          state_r,   state_nxt;
  logic            cmd_r,     cmd_nxt;
  ukl_pkg::key_t   key_r,     key_nxt;
  logic [15:0]     pay_r,     pay_nxt;
  logic [CW-1:0]   addr_r,    addr_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0]   count_r,   count_nxt;

  // Pending result, then output register
  logic [2:0]      res_status_r, res_status_nxt;
  logic [15:0]     res_found_r,  res_found_nxt;
  logic [3:0]      res_slot_r,   res_slot_nxt;
  logic            out_valid_r,  out_valid_nxt;
  logic [2:0]      out_status_r, out_status_nxt;
  logic [15:0]     out_found_r,  out_found_nxt;
  logic [3:0]      out_slot_r,   out_slot_nxt;

  // Storage ports
  logic                    key_we;
  logic                    pay_we;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic [ukl_pkg::KeyW-1:0] rd_key_raw;
  ukl_pkg::key_t           rd_key;
  logic [15:0]             rd_pay;
  logic                    key_eq;
  logic                    len_ok;

  // Keep only the first len bytes for a valid length; any other length keeps all bytes.
  function automatic ukl_pkg::key_t make_key(input logic [63:0] lo,
                                             input logic [15:0] hi,
                                             input logic [3:0]  len);
    ukl_pkg::key_t k;
    k.len = len;
    k.lo  = lo;
    k.hi  = hi;
    case (len)
      ukl_pkg::LEN4: begin
        k.lo = {32'd0, lo[31:0]};
        k.hi = 16'd0;
      end
      ukl_pkg::LEN7: begin
        k.lo = {8'd0, lo[55:0]};
        k.hi = 16'd0;
      end
      default: begin
        k.lo = lo;
        k.hi = hi;
      end
    endcase
    return k;
  endfunction

  assign len_ok = in_uid_length inside {ukl_pkg::LEN4, ukl_pkg::LEN7, ukl_pkg::LEN10};

  ukl_ram #(
    .WIDTH (ukl_pkg::KeyW),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (rd_key_raw)
  );

  ukl_ram #(
    .WIDTH (16),
    .DEPTH (ENTRIES)
  ) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (wr_addr),
    .wdata (pay_r),
    .raddr (rd_addr),
    .rdata (rd_pay)
  );

  assign rd_key = ukl_pkg::key_t'(rd_key_raw);

  ukl_key_cmp u_cmp (
    .stored_key (rd_key),
    .probe_key  (key_r),
    .eq         (key_eq)
  );

  assign rd_addr = addr_r[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    addr_nxt       = addr_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    // Drop the output item once taken
    out_valid_nxt  = out_valid_r & ~out_ready;
    key_we         = 1'b0;
    pay_we         = 1'b0;
    wr_addr        = cmp_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          key_nxt        = make_key(in_uid_low, in_uid_high, in_uid_length);
          pay_nxt        = in_payload;
          addr_nxt       = '0;
          cmp_vld_nxt    = 1'b0;
          res_found_nxt  = 16'd0;
          res_slot_nxt   = 4'd0;
          if (!len_ok) begin
            res_status_nxt = (in_command == ukl_pkg::CMD_LOOKUP) ?
                             ukl_pkg::STAT_MISS : ukl_pkg::STAT_BADLEN;
            state_nxt      = ST_FIN;
          end else begin
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (cmp_vld_r && key_eq) begin
          // First match in append order wins
          cmp_vld_nxt  = 1'b0;
          res_slot_nxt = 4'(cmp_idx_r);
          if (cmd_r == ukl_pkg::CMD_LOOKUP) begin
            res_status_nxt = ukl_pkg::STAT_HIT;
            res_found_nxt  = rd_pay;
          end else begin
            pay_we         = 1'b1;
            wr_addr        = cmp_idx_r;
            res_status_nxt = ukl_pkg::STAT_REPLACED;
          end
          state_nxt = ST_FIN;
        end else if (addr_r == count_r) begin
          // Scan exhausted without a match
          cmp_vld_nxt = 1'b0;
          if (cmd_r == ukl_pkg::CMD_LOOKUP) begin
            res_status_nxt = ukl_pkg::STAT_MISS;
          end else if (count_r == CW'(ENTRIES)) begin
            res_status_nxt = ukl_pkg::STAT_FULL;
          end else begin
            key_we         = 1'b1;
            pay_we         = 1'b1;
            wr_addr        = count_r[AW-1:0];
            res_slot_nxt   = 4'(count_r);
            res_status_nxt = ukl_pkg::STAT_ADDED;
            count_nxt      = count_r + 1'b1;
          end
          state_nxt = ST_FIN;
        end else begin
          // Advance: read this slot, compare it next cycle
          addr_nxt    = addr_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = addr_r[AW-1:0];
        end
      end

      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_vld_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    addr_r       <= addr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_payload = out_found_r;
  assign out_entry_slot    = out_slot_r;

  // Entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count exceeds table size");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  // Every append grows the count by one
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("append without count advance");

endmodule
